// ----- design/tmgr_pkg.sv -----
package tmgr_pkg;

	// Input transaction modes
	localparam logic [1:0] MODE_MARKUP = 2'd0;
	localparam logic [1:0] MODE_FONT   = 2'd1;
	localparam logic [1:0] MODE_BEGIN  = 2'd2;

	// Markup byte codes
	localparam logic [7:0] CODE_SPACE      = 8'h26;
	localparam logic [7:0] CODE_GLYPH_LAST = 8'h2A;
	localparam logic [7:0] CODE_COLOUR_LO  = 8'h40;
	localparam logic [7:0] CODE_COLOUR_HI  = 8'h4F;
	localparam logic [7:0] MARKER_LO       = 8'h28;
	localparam logic [7:0] MARKER_END      = 8'h78;

	// Screen margins
	localparam logic [11:0] LEFT_MARGIN = 12'd32;
	localparam logic [7:0]  TOP_MARGIN  = 8'd4;

	// Queue geometry
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// Row counter width, covers up to eight rows per glyph
	localparam int ROW_W = 3;

	// Queue command kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_DRAW  = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] byte_value;
		logic [8:0] font_index;
	} cmd_t;

	typedef struct packed {
		logic [15:0] pixel_offset;
		logic [7:0]  pixel_mask;
		logic [3:0]  ink_colour;
		logic        last_row;
	} row_t;

	// Command passed from parser to renderer
	typedef struct packed {
		logic        kind;
		logic [8:0]  addr;
		logic [7:0]  data;
		logic [15:0] offset;
		logic [3:0]  colour;
	} qent_t;

	// Queue push side
	typedef struct packed {
		logic  push;
		qent_t ent;
	} qpush_t;

	// Queue head as seen by the renderer
	typedef struct packed {
		logic  valid;
		qent_t ent;
	} qhead_t;

	function automatic logic [3:0] attr_colour(input logic [7:0] a);
		attr_colour = {a[6], a[2:0]};
	endfunction

endpackage

// ----- design/tmgr_front.sv -----
module tmgr_front #(
	parameter int GLYPH_COUNT = 43,
	parameter int GLYPH_ROWS  = 6,
	parameter int LINE_PITCH  = 320
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  tmgr_pkg::cmd_t cmd,
	output tmgr_pkg::qpush_t qp
);
	import tmgr_pkg::*;

	localparam logic [2:0] PH_SEEK    = 3'd0;
	localparam logic [2:0] PH_Y       = 3'd1;
	localparam logic [2:0] PH_ATTR    = 3'd2;
	localparam logic [2:0] PH_COUNT   = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;

	localparam logic [8:0]  GC    = 9'(GLYPH_COUNT);
	localparam logic [9:0]  SS    = 10'(GLYPH_COUNT * GLYPH_ROWS);
	localparam logic [8:0]  ROWS9 = 9'(GLYPH_ROWS);
	localparam logic [15:0] PITCH = 16'(LINE_PITCH);

	logic [2:0]  phase_q, phase_d;
	logic [11:0] cell_x_q, cell_x_d;
	logic [15:0] ybase_q, ybase_d;
	logic [3:0]  colour_q, colour_d;
	logic [7:0]  left_q, left_d;
	logic [7:0]  b;
	logic [15:0] y16;
	logic        is_marker;

	assign b         = cmd.byte_value;
	assign y16       = {8'd0, b} + {8'd0, TOP_MARGIN} - 16'd5;
	assign is_marker = (b[2:0] == 3'd0) && (b >= MARKER_LO) && (b < MARKER_END);

	// Parser: next state and command to the renderer
	always_comb begin
		phase_d    = phase_q;
		cell_x_d   = cell_x_q;
		ybase_d    = ybase_q;
		colour_d   = colour_q;
		left_d     = left_q;
		qp.push    = 1'b0;
		qp.ent.kind   = CMD_DRAW;
		qp.ent.addr   = 9'({1'b0, b} * ROWS9);
		qp.ent.data   = b;
		qp.ent.offset = ybase_q + {4'd0, cell_x_q};
		qp.ent.colour = colour_q;
		if (accept) begin
			if (cmd.mode == MODE_FONT) begin
				qp.ent.kind = CMD_WRITE;
				qp.ent.addr = cmd.font_index;
				qp.push     = ({1'b0, cmd.font_index} < SS);
			end else if (cmd.mode == MODE_BEGIN) begin
				phase_d = PH_SEEK;
				left_d  = 8'd0;
			end else if (cmd.mode == MODE_MARKUP) begin
				unique case (phase_q)
					PH_SEEK: begin
						if (is_marker) begin
							cell_x_d = LEFT_MARGIN + {4'd0, b};
							phase_d  = PH_Y;
						end
					end
					PH_Y: begin
						// Row base of the glyph's first line, wraps at 16 bits
						ybase_d = 16'(y16 * PITCH);
						phase_d = PH_ATTR;
					end
					PH_ATTR: begin
						colour_d = attr_colour(b);
						phase_d  = PH_COUNT;
					end
					PH_COUNT: begin
						left_d  = b;
						phase_d = (b == 8'd0) ? PH_SEEK : PH_PAYLOAD;
					end
					PH_PAYLOAD: begin
						if (b == CODE_SPACE) begin
							cell_x_d = cell_x_q + 12'd8;
						end else if (b <= CODE_GLYPH_LAST) begin
							qp.push  = ({1'b0, b} < GC);
							cell_x_d = cell_x_q + 12'd8;
						end else if (b >= CODE_COLOUR_LO && b <= CODE_COLOUR_HI) begin
							colour_d = attr_colour(b);
						end else begin
							cell_x_d = cell_x_q + 12'd8;
						end
						left_d = left_q - 8'd1;
						if (left_q == 8'd1) begin
							phase_d = PH_SEEK;
						end
					end
					default: begin
						phase_d = PH_SEEK;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK;
			cell_x_q <= 12'd0;
			ybase_q  <= 16'd0;
			colour_q <= 4'd0;
			left_q   <= 8'd0;
		end else begin
			phase_q  <= phase_d;
			cell_x_q <= cell_x_d;
			ybase_q  <= ybase_d;
			colour_q <= colour_d;
			left_q   <= left_d;
		end
	end

endmodule

// ----- design/tmgr_queue.sv -----
module tmgr_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  tmgr_pkg::qpush_t qp,
	input  logic             pop,
	output tmgr_pkg::qhead_t head,
	output logic             full
);
	import tmgr_pkg::*;

	qent_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           do_pop;

	assign full       = (count_q == (QAW+1)'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.ent   = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// Entry storage
	always_ff @(posedge clk) begin
		if (qp.push) begin
			mem_q[wr_ptr_q] <= qp.ent;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (qp.push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (qp.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!qp.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- design/tmgr_back.sv -----
module tmgr_back #(
	parameter int GLYPH_COUNT = 43,
	parameter int GLYPH_ROWS  = 6,
	parameter int LINE_PITCH  = 320
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tmgr_pkg::qhead_t head,
	output logic             pop,
	output logic             wr_valid,
	input  logic             wr_stall,
	output tmgr_pkg::row_t   wr
);
	import tmgr_pkg::*;

	localparam int          STORE = GLYPH_COUNT * GLYPH_ROWS;
	localparam int          AW    = (STORE > 1) ? $clog2(STORE) : 1;
	localparam logic [15:0] PITCH = 16'(LINE_PITCH);
	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

	logic [7:0]       store_q [STORE];
	logic [ROW_W-1:0] row_q;
	logic [15:0]      off_q;
	logic [15:0]      cur_off;
	logic [8:0]       rd_addr;
	logic             is_last;
	logic             do_write;
	logic             issue;

	logic             valid_s1;
	logic [7:0]       mask_s1;
	logic [15:0]      off_s1;
	logic [3:0]       colour_s1;
	logic             last_s1;

	logic             out_valid_q;
	row_t             out_q;
	logic             out_ready;
	logic             s1_move;
	logic             s1_free;

	// Handshake between read stage and output register
	assign out_ready = !out_valid_q || !wr_stall;
	assign s1_move   = valid_s1 && out_ready;
	assign s1_free   = !valid_s1 || s1_move;

	// Command decode at queue head
	assign do_write = head.valid && (head.ent.kind == CMD_WRITE);
	assign issue    = head.valid && (head.ent.kind == CMD_DRAW) && s1_free;
	assign is_last  = (row_q == LAST_ROW);
	assign cur_off  = (row_q == '0) ? head.ent.offset : off_q;
	assign rd_addr  = head.ent.addr + 9'(row_q);
	assign pop      = do_write || (issue && is_last);

	// Font store, one write or one read per cycle
	always_ff @(posedge clk) begin
		if (do_write) begin
			store_q[head.ent.addr[AW-1:0]] <= head.ent.data;
		end
		if (issue) begin
			mask_s1 <= store_q[rd_addr[AW-1:0]];
		end
	end

	// Row sequencer and read stage metadata
	always_ff @(posedge clk) begin
		if (issue) begin
			off_q     <= cur_off + PITCH;
			off_s1    <= cur_off;
			colour_s1 <= head.ent.colour;
			last_s1   <= is_last;
		end
		if (s1_move) begin
			out_q.pixel_offset <= off_s1;
			out_q.pixel_mask   <= mask_s1;
			out_q.ink_colour   <= colour_s1;
			out_q.last_row     <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				row_q <= is_last ? '0 : row_q + 1'b1;
			end
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!wr_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign wr_valid = out_valid_q;
	assign wr       = out_q;

endmodule

// ----- design/text_markup_glyph_renderer_core.sv -----
// Markup glyph renderer.
// The cmd channel takes one transaction per cycle when not stalled:
// markup bytes (mode 0), font store writes (mode 1) and buffer restarts
// (mode 2). A parser front end decodes records and pushes font writes
// and glyph draws into a four-entry queue; cmd_stall is high while that
// queue is full. The wr channel gives framebuffer row writes: offset,
// 8-pixel mask, colour, and last_row on the final row of each glyph.
// The renderer writes a queued font write into the font store as it pops
// it, and reads a drawn glyph as GLYPH_ROWS rows through the single read
// port of the font store, one row per cycle while the read stage is free.
// A glyph's first row goes from the queue through the read stage and the
// output register before it is valid on wr.
// Reset clears the parser state, the queue pointers, the row counter and
// the valid flags of the read stage and the output register; the font
// store keeps its contents and must be loaded before glyphs are drawn.
// While wr_stall is high the row write holds on wr; the renderer keeps
// one more row in its read stage and the queue keeps filling until full.
module text_markup_glyph_renderer_core #(
	parameter int GLYPH_COUNT = 43,
	parameter int GLYPH_ROWS  = 6,
	parameter int LINE_PITCH  = 320
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tmgr_pkg::cmd_t cmd,
	output logic           wr_valid,
	input  logic           wr_stall,
	output tmgr_pkg::row_t wr
);
	import tmgr_pkg::*;

	qpush_t qp;
	qhead_t head;
	logic   pop;
	logic   full;
	logic   accept;

	assign cmd_stall = full;
	assign accept    = cmd_valid && !full;

	tmgr_front #(
		.GLYPH_COUNT(GLYPH_COUNT),
		.GLYPH_ROWS (GLYPH_ROWS),
		.LINE_PITCH (LINE_PITCH)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.cmd   (cmd),
		.qp    (qp)
	);

	tmgr_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.qp    (qp),
		.pop   (pop),
		.head  (head),
		.full  (full)
	);

	tmgr_back #(
		.GLYPH_COUNT(GLYPH_COUNT),
		.GLYPH_ROWS (GLYPH_ROWS),
		.LINE_PITCH (LINE_PITCH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.wr_valid(wr_valid),
		.wr_stall(wr_stall),
		.wr      (wr)
	);

endmodule
